/* hw/rtl/dqs_pkg.sv */
// Shared types, constants and index helpers for the bounded deque core.
// Used by dqs_acc and deque_with_search_and_sum_core. No dependencies.
package dqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 5;
    localparam int ENT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int OUT_RAW = STAT_W + 1 + POS_W + DATA_W + ENT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_SEARCH     = 3'd4,
        F_SUM        = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_acc_ctl;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] tmp;
        tmp = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
        if (tmp >= (CNT_W+1)'(DEPTH)) begin
            tmp = tmp - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(tmp);
    endfunction

endpackage

/* hw/rtl/deque_with_search_and_sum_core.sv */
// Bounded deque of signed 32-bit values with search and sum over a circular buffer.
// Push/pop/unused codes pass through the execute and finish states to o_m_tvalid; search
// and sum also scan the entries (one buffer read per cycle through the scan unit).
// One command is handled at a time and an output stall holds the next; tready is high
// only while idle, and a result waits in the output register while the next is taken.
// Reset (i_rst_n low, synchronous) empties the deque; buffer contents stay unset.
module deque_with_search_and_sum_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,  // [31:0] operand_value
    input  logic [2:0]                  i_s_tuser,  // [2:0] func
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [1:0] status, [2] found, [7:3] position, [39:8] total, [44:40] entries, pad
    output logic [dqs_pkg::OUT_W-1:0]   o_m_tdata
);

    logic [dqs_pkg::DATA_W-1:0] r_mem [dqs_pkg::DEPTH];

    dqs_pkg::t_state             r_state, n_state;
    logic [dqs_pkg::FUNC_W-1:0]  r_cmd, n_cmd;
    logic [dqs_pkg::DATA_W-1:0]  r_val, n_val;
    logic [dqs_pkg::IDX_W-1:0]   r_front, n_front;
    logic [dqs_pkg::CNT_W-1:0]   r_fill, n_fill;
    dqs_pkg::t_status            r_status, n_status;
    logic [dqs_pkg::IDX_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [dqs_pkg::CNT_W-1:0]   r_rd_cnt, n_rd_cnt;
    logic                        r_dv, n_dv;
    logic [dqs_pkg::CNT_W-1:0]   r_dpos, n_dpos;
    logic [dqs_pkg::DATA_W-1:0]  r_rdata;
    logic                        r_ovalid, n_ovalid;
    logic [dqs_pkg::OUT_W-1:0]   r_odata, n_odata;

    logic                        w_we;
    logic [dqs_pkg::IDX_W-1:0]   w_waddr;
    dqs_pkg::t_acc_ctl           w_acc_ctl;
    logic [dqs_pkg::DATA_W-1:0]  w_sum;
    logic                        w_found;
    logic [dqs_pkg::CNT_W-1:0]   w_pos;
    logic                        w_out_free;

    assign w_out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_val;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dqs_pkg::S_IDLE;
            r_front  <= '0;
            r_fill   <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_fill   <= n_fill;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd_ptr <= n_rd_ptr;
        r_rd_cnt <= n_rd_cnt;
        r_dpos   <= n_dpos;
        r_odata  <= n_odata;
    end

    always_comb begin
        logic [dqs_pkg::DATA_W-1:0] v_total;
        logic                       v_found;
        logic [dqs_pkg::CNT_W-1:0]  v_pos;

        n_state   = r_state;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_front   = r_front;
        n_fill    = r_fill;
        n_status  = r_status;
        n_rd_ptr  = r_rd_ptr;
        n_rd_cnt  = r_rd_cnt;
        n_dv      = 1'b0;
        n_dpos    = r_dpos;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_odata   = r_odata;
        w_we      = 1'b0;
        w_waddr   = r_front;
        w_acc_ctl = '{clear: 1'b0, valid: r_dv};
        v_total   = '0;
        v_found   = 1'b0;
        v_pos     = '0;

        case (r_state)
            dqs_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = i_s_tuser;
                    n_val   = i_s_tdata;
                    n_state = dqs_pkg::S_EXEC;
                end
            end
            dqs_pkg::S_EXEC: begin
                w_acc_ctl.clear = 1'b1;
                n_status = dqs_pkg::ST_OK;
                n_rd_ptr = r_front;
                n_rd_cnt = '0;
                n_state  = dqs_pkg::S_FIN;
                case (r_cmd)
                    dqs_pkg::F_PUSH_FRONT: begin
                        if (r_fill == dqs_pkg::CNT_W'(dqs_pkg::DEPTH)) begin
                            n_status = dqs_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = dqs_pkg::idx_dec(r_front);
                            n_front = dqs_pkg::idx_dec(r_front);
                            n_fill  = r_fill + dqs_pkg::CNT_W'(1);
                        end
                    end
                    dqs_pkg::F_PUSH_BACK: begin
                        if (r_fill == dqs_pkg::CNT_W'(dqs_pkg::DEPTH)) begin
                            n_status = dqs_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = dqs_pkg::idx_add(r_front, r_fill);
                            n_fill  = r_fill + dqs_pkg::CNT_W'(1);
                        end
                    end
                    dqs_pkg::F_POP_FRONT: begin
                        if (r_fill == '0) begin
                            n_status = dqs_pkg::ST_EMPTY;
                        end else begin
                            n_front = dqs_pkg::idx_inc(r_front);
                            n_fill  = r_fill - dqs_pkg::CNT_W'(1);
                        end
                    end
                    dqs_pkg::F_POP_BACK: begin
                        if (r_fill == '0) begin
                            n_status = dqs_pkg::ST_EMPTY;
                        end else begin
                            n_fill = r_fill - dqs_pkg::CNT_W'(1);
                        end
                    end
                    dqs_pkg::F_SEARCH, dqs_pkg::F_SUM: begin
                        n_state = dqs_pkg::S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            dqs_pkg::S_SCAN: begin
                if (r_rd_cnt != r_fill) begin
                    n_dv     = 1'b1;
                    n_dpos   = r_rd_cnt + dqs_pkg::CNT_W'(1);
                    n_rd_cnt = r_rd_cnt + dqs_pkg::CNT_W'(1);
                    n_rd_ptr = dqs_pkg::idx_inc(r_rd_ptr);
                end else if (!r_dv) begin
                    n_state = dqs_pkg::S_FIN;
                end
            end
            dqs_pkg::S_FIN: begin
                if (r_cmd == dqs_pkg::F_SEARCH) begin
                    v_found = w_found;
                    v_pos   = w_pos;
                end
                if (r_cmd == dqs_pkg::F_SUM) begin
                    v_total = w_sum;
                end
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = dqs_pkg::OUT_W'({dqs_pkg::ENT_W'(r_fill), v_total,
                                                dqs_pkg::POS_W'(v_pos), v_found,
                                                r_status});
                    n_state  = dqs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dqs_pkg::S_IDLE;
            end
        endcase
    end

    dqs_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_acc_ctl),
        .i_data  (r_rdata),
        .i_key   (r_val),
        .i_pos   (r_dpos),
        .o_sum   (w_sum),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign o_s_tready = (r_state == dqs_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
        else $error("fill count beyond depth");

    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == dqs_pkg::S_SCAN))
        else $error("read data pending outside scan");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqs_pkg::S_SCAN) |-> (r_rd_cnt <= r_fill))
        else $error("scan ran past held entries");

    a_entries_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_state == dqs_pkg::S_IDLE || r_state == dqs_pkg::S_EXEC))
        |-> (r_odata[44:40] == dqs_pkg::ENT_W'(r_fill)))
        else $error("reported entries differ from fill count");

endmodule

/* hw/rtl/dqs_acc.sv */
// Shared scan unit: running wrap-around sum and first-match compare.
// Depends on dqs_pkg.
module dqs_acc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dqs_pkg::t_acc_ctl            i_ctl,
    input  logic [dqs_pkg::DATA_W-1:0]   i_data,
    input  logic [dqs_pkg::DATA_W-1:0]   i_key,
    input  logic [dqs_pkg::CNT_W-1:0]    i_pos,
    output logic [dqs_pkg::DATA_W-1:0]   o_sum,
    output logic                         o_found,
    output logic [dqs_pkg::CNT_W-1:0]    o_pos
);

    logic [dqs_pkg::DATA_W-1:0] r_sum;
    logic                       r_found;
    logic [dqs_pkg::CNT_W-1:0]  r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_ctl.clear) begin
            r_sum   <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_ctl.valid) begin
            r_sum <= r_sum + i_data;
            if (!r_found && (i_data == i_key)) begin
                r_found <= 1'b1;
                r_pos   <= i_pos;
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_found = r_found;
    assign o_pos   = r_pos;

    a_pos_with_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_pos != '0))
        else $error("match recorded without a position");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_ctl.clear) |=> (r_found && $stable(r_pos)))
        else $error("first match overwritten during scan");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_sum == '0 && !r_found && r_pos == '0))
        else $error("scan unit not cleared");

endmodule
